// File: src/edcs_pkg.sv
package edcs_pkg;

  localparam int FracBits = 21;
  localparam int TabDepth = 1024;
  localparam int IdxW     = 11;
  localparam int DivW     = 35;

  localparam logic [21:0] OneQ    = 22'd2097152;
  localparam logic [21:0] HalfPiQ = 22'd3294199;
  localparam logic [21:0] NewWQ   = 22'd801041;
  localparam logic [21:0] FoldQ   = 22'd1296111;

  localparam logic [14:0] InGainRst  = 15'd8192;
  localparam logic [15:0] AttackRst  = 16'd12583;
  localparam logic [11:0] DecayRst   = 12'd428;
  localparam logic [14:0] OutGainRst = 15'd8192;

  localparam logic [1:0] RegInGain  = 2'd0;
  localparam logic [1:0] RegAttack  = 2'd1;
  localparam logic [1:0] RegDecay   = 2'd2;
  localparam logic [1:0] RegOutGain = 2'd3;

  typedef logic [21:0] cos_tab_t [0:TabDepth];

  // 1-cos over 0..pi/2 by a Taylor series in Q30, rounded to Q1.21.
  // The series terms divide by (2k+1)(2k+2) for k = 1..6.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t         tab;
    longint unsigned  theta;
    longint unsigned  x2;
    longint unsigned  term;
    longint           sum;
    longint           e;
    for (int i = 0; i <= TabDepth; i++) begin
      theta = (longint'(i) * (longint'(HalfPiQ) << 9)) / TabDepth;
      x2    = (theta * theta) >> 30;
      term  = x2 >> 1;
      sum   = longint'(term);
      term  = ((term * x2) >> 30) / 12;
      sum   = sum - longint'(term);
      term  = ((term * x2) >> 30) / 30;
      sum   = sum + longint'(term);
      term  = ((term * x2) >> 30) / 56;
      sum   = sum - longint'(term);
      term  = ((term * x2) >> 30) / 90;
      sum   = sum + longint'(term);
      term  = ((term * x2) >> 30) / 132;
      sum   = sum - longint'(term);
      term  = ((term * x2) >> 30) / 182;
      sum   = sum + longint'(term);
      if (sum < 0) sum = 0;
      e = (sum + 256) >>> 9;
      if (e > longint'(OneQ)) e = longint'(OneQ);
      tab[i] = e[21:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

// File: src/envelope_driven_cosine_saturator.sv
// A new item is taken once the sequencer is idle, even while the previous result still
// waits in the output register; the sequencer handles one item at a time.
// The bit-serial divider by pi/2 is used twice per channel.
// Reset (rst_ni low, asynchronous): registers return to their defaults, envelope to 1.0,
// previous shape values to zero.
module envelope_driven_cosine_saturator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // in_left [23:0], in_right [47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_left [23:0], out_right [47:24]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import edcs_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_GL   = 5'd1;
  localparam logic [4:0] S_GR   = 5'd2;
  localparam logic [4:0] S_ENV  = 5'd3;
  localparam logic [4:0] S_MB   = 5'd4;
  localparam logic [4:0] S_CLIP = 5'd5;
  localparam logic [4:0] S_DIVI = 5'd6;
  localparam logic [4:0] S_T0   = 5'd7;
  localparam logic [4:0] S_T1   = 5'd8;
  localparam logic [4:0] S_T2   = 5'd9;
  localparam logic [4:0] S_DIVF = 5'd10;
  localparam logic [4:0] S_SHP  = 5'd11;
  localparam logic [4:0] S_B1   = 5'd12;
  localparam logic [4:0] S_B2   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_OG   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]  state_q;
  logic [14:0] ig_q, og_q;
  logic [15:0] atk_q;
  logic [11:0] dcy_q;
  logic [47:0] x_q;
  logic signed [26:0] gl_q, gr_q;
  logic [21:0] env_q, mb_q, bd_q, wout_q, dry_q;
  logic [21:0] prev_l_q, prev_r_q;
  logic        ch_q;
  logic signed [22:0] c_q;
  logic [DivW-1:0] num_q, quo_q;
  logic [21:0] rem_q;
  logic [5:0]  cnt_q;
  logic [IdxW-1:0] idx_q;
  logic [21:0] fr_q, tab_q, lo_q, sh_q, blend_q;
  logic signed [45:0] acc_q;
  logic signed [24:0] y_q;
  logic [23:0] outl_q, outr_q;
  logic        mval_q;
  logic [47:0] mdata_q;

  // Shared restoring-division step by pi/2, one quotient bit per cycle.
  logic [22:0] rem_sh;
  logic        div_ge;
  logic [21:0] rem_nx;
  assign rem_sh = {rem_q, num_q[DivW-1]};
  assign div_ge = rem_sh >= {1'b0, HalfPiQ};
  assign rem_nx = div_ge ? 22'(rem_sh - {1'b0, HalfPiQ}) : rem_sh[21:0];

  // Input gain.
  logic signed [23:0] gx;
  logic signed [39:0] gprod;
  assign gx    = (state_q == S_GL) ? $signed(x_q[23:0]) : $signed(x_q[47:24]);
  assign gprod = 40'(gx) * 40'($signed({1'b0, ig_q})) + 40'sd4096;

  // Envelope follower.
  logic [26:0] al, ar, sense;
  logic [27:0] e0, e1, e2;
  always_comb begin
    al    = gl_q[26] ? 27'(-gl_q) : 27'(gl_q);
    ar    = gr_q[26] ? 27'(-gr_q) : 27'(gr_q);
    sense = (ar > al) ? ar : al;
    e0    = {6'd0, env_q};
    e1    = (e0 < {1'b0, sense}) ? 28'(e0 + {12'd0, atk_q}) : e0;
    if (e1 > {6'd0, OneQ}) e1 = {6'd0, OneQ};
    e2    = e1;
    if (e1 > {1'b0, sense}) e2 = (e1 > {16'd0, dcy_q}) ? 28'(e1 - {16'd0, dcy_q}) : 28'd0;
  end

  logic [43:0] mbp;
  logic [21:0] mb_nx;
  assign mbp   = 44'(env_q) * 44'(NewWQ) + 44'd1048576;
  assign mb_nx = mbp[42:21];

  // Clip to +-pi/2.
  logic signed [26:0] gsel;
  logic signed [22:0] c_nx;
  logic [21:0]        mag;
  always_comb begin
    gsel = ch_q ? gr_q : gl_q;
    if (gsel > $signed({5'd0, HalfPiQ})) c_nx = $signed({1'b0, HalfPiQ});
    else if (gsel < -$signed({5'd0, HalfPiQ})) c_nx = -$signed({1'b0, HalfPiQ});
    else c_nx = gsel[22:0];
    mag = c_nx[22] ? 22'(-c_nx) : 22'(c_nx);
  end

  logic [IdxW-1:0] idx_nx;
  assign idx_nx = (idx_q == IdxW'(TabDepth)) ? idx_q : IdxW'(idx_q + 1'b1);

  logic [21:0] diff;
  logic [43:0] dprod;
  assign diff  = tab_q - lo_q;
  assign dprod = 44'(diff) * 44'(fr_q) + 44'({1'b0, HalfPiQ[21:1]});

  logic [21:0] prev;
  logic [44:0] bsum;
  assign prev = ch_q ? prev_r_q : prev_l_q;
  assign bsum = 45'(acc_q[43:0]) + 45'(sh_q) * 45'(bd_q) + 45'd1048576;

  logic signed [45:0] bw, msum;
  assign bw   = $signed({2'b0, 44'(blend_q) * 44'(wout_q)});
  assign msum = ((c_q > 0) ? (acc_q + bw) : (acc_q - bw)) + 46'sd1048576;

  logic signed [40:0] zp;
  logic signed [27:0] z;
  logic [23:0]        zsat;
  always_comb begin
    zp = 41'(y_q) * 41'($signed({1'b0, og_q})) + 41'sd4096;
    z  = zp[40:13];
    if (z > 28'sd8388607) zsat = 24'h7FFFFF;
    else if (z < -28'sd8388608) zsat = 24'h800000;
    else zsat = z[23:0];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ig_q  <= InGainRst;
      atk_q <= AttackRst;
      dcy_q <= DecayRst;
      og_q  <= OutGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegInGain:  ig_q  <= cfg_wdata_i[14:0];
        RegAttack:  atk_q <= cfg_wdata_i;
        RegDecay:   dcy_q <= cfg_wdata_i[11:0];
        RegOutGain: og_q  <= cfg_wdata_i[14:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      env_q    <= OneQ;
      prev_l_q <= '0;
      prev_r_q <= '0;
      mval_q   <= 1'b0;
      ch_q     <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
    end else begin
      if (mval_q && m_axis_tready && (state_q != S_DONE)) mval_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x_q     <= s_axis_tdata;
            state_q <= S_GL;
          end
        end
        S_GL: begin
          gl_q    <= gprod[39:13];
          state_q <= S_GR;
        end
        S_GR: begin
          gr_q    <= gprod[39:13];
          state_q <= S_ENV;
        end
        S_ENV: begin
          env_q   <= e2[21:0];
          state_q <= S_MB;
        end
        S_MB: begin
          mb_q    <= mb_nx;
          bd_q    <= OneQ - mb_nx;
          wout_q  <= (env_q > FoldQ) ? 22'({FoldQ, 1'b0} - {1'b0, env_q}) : env_q;
          dry_q   <= OneQ - env_q;
          ch_q    <= 1'b0;
          state_q <= S_CLIP;
        end
        S_CLIP: begin
          c_q     <= c_nx;
          num_q   <= {3'd0, mag, 10'd0};
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= 6'(DivW - 1);
          state_q <= S_DIVI;
        end
        S_DIVI, S_DIVF: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[DivW-2:0], div_ge};
          num_q <= {num_q[DivW-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= (state_q == S_DIVI) ? S_T0 : S_SHP;
        end
        S_T0: begin
          tab_q   <= CosTab[quo_q[IdxW-1:0]];
          idx_q   <= quo_q[IdxW-1:0];
          fr_q    <= rem_q;
          state_q <= S_T1;
        end
        S_T1: begin
          lo_q    <= tab_q;
          tab_q   <= CosTab[idx_nx];
          state_q <= S_T2;
        end
        S_T2: begin
          num_q   <= dprod[DivW-1:0];
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= 6'(DivW - 1);
          state_q <= S_DIVF;
        end
        S_SHP: begin
          sh_q    <= 22'(lo_q + quo_q[21:0]);
          state_q <= S_B1;
        end
        S_B1: begin
          acc_q   <= $signed({2'b0, 44'(prev) * 44'(mb_q)});
          state_q <= S_B2;
        end
        S_B2: begin
          blend_q <= bsum[42:21];
          if (ch_q) prev_r_q <= sh_q;
          else prev_l_q <= sh_q;
          state_q <= S_M1;
        end
        S_M1: begin
          acc_q   <= 46'(c_q) * 46'($signed({1'b0, dry_q}));
          state_q <= S_M2;
        end
        S_M2: begin
          y_q     <= msum[45:21];
          state_q <= S_OG;
        end
        S_OG: begin
          if (ch_q) begin
            outr_q  <= zsat;
            state_q <= S_DONE;
          end else begin
            outl_q  <= zsat;
            ch_q    <= 1'b1;
            state_q <= S_CLIP;
          end
        end
        S_DONE: begin
          if (!mval_q || m_axis_tready) begin
            mval_q  <= 1'b1;
            mdata_q <= {outr_q, outl_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni) env_q <= OneQ)
    else $error("envelope above 1.0");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q < HalfPiQ)
    else $error("divider remainder out of range");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_GL)
    else $error("accepted item did not start");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mval_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done step");
`endif

endmodule
